>>> sv/mte_pkg.sv
package mte_pkg;

    // request codes
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_ADD    = 2'd1;
    localparam logic [1:0] REQ_CANCEL = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    // result codes
    localparam logic KIND_EXPIRY = 1'b0;
    localparam logic KIND_ACK    = 1'b1;
    localparam logic STAT_OK     = 1'b0;
    localparam logic STAT_FULL   = 1'b1;

    // register index (paddr[2])
    localparam logic REG_RUN_EN = 1'b0;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] timer_id;
        logic [31:0] delay_ticks;
    } t_req;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] result_id;
        logic        result_status;
        logic        last_result;
    } t_res;

    typedef struct packed {
        logic        vld;
        logic [15:0] id;
        logic [31:0] start;
        logic [31:0] delay;
    } t_entry;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_ROT,
        CELL_PACK,
        CELL_ADD,
        CELL_CLR
    } t_cell_op;

    typedef struct packed {
        logic        ack;
        logic        ev;
        logic        close;
        logic [15:0] id;
        logic        status;
    } t_buf_cmd;

    typedef struct packed {
        logic out_free;
        logic pend_vld;
    } t_buf_sts;

endpackage

>>> sv/multi_timer_expiry_table.sv
// Table of up to DEPTH one-shot timers kept in insertion order in a row of
// cells; cell 0 is the head. For add and clear the word is taken in the idle
// state and the acknowledge goes to the output register from the ACK state
// once the output is free. A tick with run_enable clear only advances the
// tick count and returns nothing. A tick with run_enable set, and a cancel,
// rotate the whole row once through the head compare unit (expired or
// matching entries are dropped on the way), then let the row settle back into
// a packed prefix, then flush the last expiry or the acknowledge. The rotation
// stalls while the output side holds off. Only one item is in work at a time;
// the next is taken once the table is packed again and the last expiry or the
// acknowledge has gone to the output register.
module multi_timer_expiry_table import mte_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  t_req        i_req,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output t_res        o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW-1:0] CNT_LAST = CW'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROT,
        S_PACK,
        S_FLUSH,
        S_ACK
    } t_state;

    t_state        r_state;
    logic          r_run_en;
    logic [31:0]   r_tick;
    logic [CW-1:0] r_cnt;
    logic          r_is_cancel;
    logic [15:0]   r_key;
    logic [15:0]   r_ack_id;
    logic          r_ack_status;

    t_entry        w_ent [DEPTH];
    logic [DEPTH-1:0] w_gap;
    t_entry        w_head;
    t_entry        w_tail_in;
    t_entry        w_new;
    t_cell_op      w_op;
    t_buf_cmd      w_buf_cmd;
    t_buf_sts      w_buf_sts;
    logic          w_acc;
    logic          w_cfg_wr;
    logic          w_hit;
    logic          w_ev_need;
    logic          w_step;
    logic          w_packed;
    logic          w_full;

    assign w_acc       = i_req_valid && o_req_ready;
    assign o_req_ready = (r_state == S_IDLE);
    assign w_cfg_wr    = psel && penable && pwrite && pready;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == REG_RUN_EN) ? {31'b0, r_run_en} : 32'b0;

    assign w_head = w_ent[0];
    assign w_full = w_ent[DEPTH-1].vld;

    // elapsed ticks compared modulo 2^32
    assign w_hit = w_head.vld && (r_is_cancel ? (w_head.id == r_key)
                                              : ((r_tick - w_head.start) > w_head.delay));
    assign w_ev_need = !r_is_cancel && w_hit;
    assign w_step    = (r_state == S_ROT)
                       && (!w_ev_need || !w_buf_sts.pend_vld || w_buf_sts.out_free);

    always_comb begin
        for (int i = 0; i < DEPTH - 1; i++) begin
            w_gap[i] = !w_ent[i].vld && w_ent[i+1].vld;
        end
        w_gap[DEPTH-1] = 1'b0;
    end
    assign w_packed = ~|w_gap;

    always_comb begin
        w_tail_in     = w_head;
        w_tail_in.vld = (r_state == S_ROT) && w_head.vld && !w_hit;
    end

    assign w_new = '{vld: 1'b1, id: i_req.timer_id, start: r_tick, delay: i_req.delay_ticks};

    always_comb begin
        w_op = CELL_HOLD;
        case (r_state)
            S_IDLE: begin
                if (w_acc && i_req.req_type == REQ_ADD) begin
                    w_op = CELL_ADD;
                end else if (w_acc && i_req.req_type == REQ_CLEAR) begin
                    w_op = CELL_CLR;
                end
            end
            S_ROT: begin
                if (w_step) begin
                    w_op = CELL_ROT;
                end
            end
            S_PACK: begin
                if (!w_packed) begin
                    w_op = CELL_PACK;
                end
            end
            default: begin
                w_op = CELL_HOLD;
            end
        endcase
    end

    always_comb begin
        w_buf_cmd.ev     = w_step && w_ev_need;
        w_buf_cmd.close  = (r_state == S_FLUSH) && w_buf_sts.out_free;
        w_buf_cmd.ack    = (r_state == S_ACK) && w_buf_sts.out_free;
        w_buf_cmd.id     = w_buf_cmd.ev ? w_head.id : r_ack_id;
        w_buf_cmd.status = r_ack_status;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry w_up;
        logic   w_dn_vld;
        if (g == DEPTH - 1) begin : g_tail
            assign w_up = w_tail_in;
        end else begin : g_mid
            assign w_up = w_ent[g+1];
        end
        if (g == 0) begin : g_head
            assign w_dn_vld = 1'b1;
        end else begin : g_rest
            assign w_dn_vld = w_ent[g-1].vld;
        end
        mte_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_op     (w_op),
            .i_up     (w_up),
            .i_dn_vld (w_dn_vld),
            .i_new    (w_new),
            .o_ent    (w_ent[g])
        );
    end

    mte_res_buf u_res_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_buf_cmd),
        .o_sts       (w_buf_sts),
        .i_res_ready (i_res_ready),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_run_en <= 1'b0;
            r_tick   <= 32'd0;
            r_cnt    <= '0;
        end else begin
            if (w_cfg_wr && paddr[2] == REG_RUN_EN) begin
                r_run_en <= pwdata[0];
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        case (i_req.req_type)
                            REQ_TICK: begin
                                r_tick <= r_tick + 32'd1;
                                if (r_run_en) begin
                                    r_is_cancel <= 1'b0;
                                    r_cnt       <= '0;
                                    r_state     <= S_ROT;
                                end
                            end
                            REQ_ADD: begin
                                r_ack_id     <= i_req.timer_id;
                                r_ack_status <= w_full ? STAT_FULL : STAT_OK;
                                r_state      <= S_ACK;
                            end
                            REQ_CANCEL: begin
                                r_run_en     <= 1'b1;
                                r_key        <= i_req.timer_id;
                                r_ack_id     <= i_req.timer_id;
                                r_ack_status <= STAT_OK;
                                r_is_cancel  <= 1'b1;
                                r_cnt        <= '0;
                                r_state      <= S_ROT;
                            end
                            default: begin
                                r_run_en     <= 1'b1;
                                r_ack_id     <= 16'd0;
                                r_ack_status <= STAT_OK;
                                r_state      <= S_ACK;
                            end
                        endcase
                    end
                end
                S_ROT: begin
                    if (w_step) begin
                        r_cnt <= r_cnt + CW'(1);
                        if (r_cnt == CNT_LAST) begin
                            r_state <= S_PACK;
                        end
                    end
                end
                S_PACK: begin
                    if (w_packed) begin
                        r_state <= r_is_cancel ? S_ACK : S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    if (!w_buf_sts.pend_vld || w_buf_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_ACK: begin
                    if (w_buf_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_packed_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> w_packed)
        else $error("timer row not packed while idle");

    a_no_pending_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_buf_sts.pend_vld)
        else $error("expiry word left pending after a tick");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_req.req_type == REQ_CLEAR) |=> !w_ent[0].vld)
        else $error("clear left a live entry");

endmodule

>>> sv/mte_cell.sv
module mte_cell import mte_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cell_op i_op,
    input  t_entry   i_up,
    input  logic     i_dn_vld,
    input  t_entry   i_new,
    output t_entry   o_ent
);

    logic        r_vld;
    logic [15:0] r_id;
    logic [31:0] r_start;
    logic [31:0] r_delay;
    t_entry      n_ent;

    assign o_ent = '{vld: r_vld, id: r_id, start: r_start, delay: r_delay};

    always_comb begin
        n_ent = o_ent;
        case (i_op)
            CELL_ROT: begin
                n_ent = i_up;
            end
            CELL_PACK: begin
                // holes bubble up, entries slide down one cell at a time
                if (!r_vld) begin
                    n_ent = i_up;
                end else if (!i_dn_vld) begin
                    n_ent.vld = 1'b0;
                end
            end
            CELL_ADD: begin
                // first free cell of the packed row takes the new timer
                if (!r_vld && i_dn_vld) begin
                    n_ent = i_new;
                end
            end
            CELL_CLR: begin
                n_ent.vld = 1'b0;
            end
            default: begin
                n_ent = o_ent;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_ent.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id    <= n_ent.id;
        r_start <= n_ent.start;
        r_delay <= n_ent.delay;
    end

endmodule

>>> sv/mte_res_buf.sv
module mte_res_buf import mte_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_buf_cmd i_cmd,
    output t_buf_sts o_sts,
    input  logic     i_res_ready,
    output logic     o_res_valid,
    output t_res     o_res
);

    logic        r_out_vld;
    t_res        r_out;
    logic        r_pend_vld;
    logic [15:0] r_pend_id;

    logic        n_out_vld;
    t_res        n_out;
    logic        n_pend_vld;
    logic [15:0] n_pend_id;

    assign o_sts.out_free = !r_out_vld || i_res_ready;
    assign o_sts.pend_vld = r_pend_vld;
    assign o_res_valid    = r_out_vld;
    assign o_res          = r_out;

    // an expiry id waits in the pending slot until we know whether another follows
    always_comb begin
        n_out_vld  = r_out_vld && !i_res_ready;
        n_out      = r_out;
        n_pend_vld = r_pend_vld;
        n_pend_id  = r_pend_id;
        if (i_cmd.ack) begin
            n_out_vld           = 1'b1;
            n_out.result_kind   = KIND_ACK;
            n_out.result_id     = i_cmd.id;
            n_out.result_status = i_cmd.status;
            n_out.last_result   = 1'b1;
        end else if (i_cmd.ev) begin
            if (r_pend_vld) begin
                n_out_vld           = 1'b1;
                n_out.result_kind   = KIND_EXPIRY;
                n_out.result_id     = r_pend_id;
                n_out.result_status = STAT_OK;
                n_out.last_result   = 1'b0;
            end
            n_pend_vld = 1'b1;
            n_pend_id  = i_cmd.id;
        end else if (i_cmd.close && r_pend_vld) begin
            n_out_vld           = 1'b1;
            n_out.result_kind   = KIND_EXPIRY;
            n_out.result_id     = r_pend_id;
            n_out.result_status = STAT_OK;
            n_out.last_result   = 1'b1;
            n_pend_vld          = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_pend_vld <= n_pend_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out     <= n_out;
        r_pend_id <= n_pend_id;
    end

endmodule
